>>> rtl/dtfs_pkg.sv
// Package for the delta-tracking flight step block.
// Holds the item and result structs, outcome and register codes and reset values.
// Depends on nothing; used by the top level and the checker of the block.
package dtfs_pkg;

	// One input item.
	typedef struct packed {
		logic        func;
		logic [31:0] distance_uniform;
		logic [31:0] accept_uniform;
		logic [6:0]  read_bin;
	} flight_t;

	// One result item.
	typedef struct packed {
		logic [1:0]  outcome;
		logic [31:0] position;
		logic [6:0]  bin_index;
		logic [31:0] bin_count;
		logic [15:0] flights_in_history;
		logic [31:0] collision_total;
		logic [31:0] escape_total;
		logic [39:0] lookup_total;
	} result_t;

	// Item function codes.
	localparam logic FUNC_FLIGHT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	// Outcome codes.
	localparam logic [1:0] OUT_VIRTUAL = 2'd0;
	localparam logic [1:0] OUT_REAL    = 2'd1;
	localparam logic [1:0] OUT_ESCAPE  = 2'd2;
	localparam logic [1:0] OUT_READ    = 2'd3;

	// Configuration register indices.
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_MAJORANT      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_MAJORANT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INNER_XS      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTER_XS      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_EDGE     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SLAB_THICK    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_BIN_WIDTH = 3'd6;

	// Register reset values.
	localparam logic [31:0] RST_MAJORANT      = 32'd128849019;
	localparam logic [31:0] RST_INV_MAJORANT  = 32'd34952533;
	localparam logic [31:0] RST_INNER_XS      = 32'd128849019;
	localparam logic [31:0] RST_OUTER_XS      = 32'd85899346;
	localparam logic [31:0] RST_STEP_EDGE     = 32'd26843546;
	localparam logic [31:0] RST_SLAB_THICK    = 32'd536870912;
	localparam logic [31:0] RST_INV_BIN_WIDTH = 32'd167772160;

	// Natural logarithm of two in Q0.30.
	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	// Number of fraction bits produced by the logarithm.
	localparam int LOG_FRAC_BITS = 28;

	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
	localparam logic [15:0] MAX16 = 16'hFFFF;
	localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

endpackage

>>> rtl/dtfs_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module dtfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                        wdata,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and registered read of the same address, which returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/delta_tracking_flight_step.sv
// Delta-tracking flight step with a collision histogram in a single-port RAM.
// Depends on dtfs_pkg and dtfs_ram.
//
// After reset the block runs a clearing pass over the histogram RAM and accepts
// no item meanwhile; configuration writes are taken at any time. It then works
// on one item at a time. A flight item with a nonzero distance uniform passes
// through a leading-zero normalisation that tests the top 16, 8, 4, 2 and 1 bits,
// the iterative squaring logarithm (one 32x32 multiplier, one result bit per
// cycle, 28 fraction bits), then the ln 2 scaling, the length multiply, the
// position add, the collision test, the decision and the result load, with the
// histogram read and write back before the result load for a real collision.
// A flight with a zero distance uniform skips the logarithm, the length multiply
// and the position add; a bin read goes through the histogram read, or straight
// to the result load for a bin beyond the histogram. The result load waits while
// an earlier result is still stalled. A new item is accepted as soon as the
// previous result has been loaded into the output register, even while that
// result still waits to be taken.
module delta_tracking_flight_step #(
	parameter int BINS = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                flight_valid,
	output logic                                flight_stall,
	input  dtfs_pkg::flight_t                   flight,
	output logic                                result_valid,
	input  logic                                result_stall,
	output dtfs_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dtfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [31:0]                         cfg_data
);

	localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
	localparam logic [11:0] TOP_BIN = 12'(BINS - 1);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_NORM, S_SQ, S_LN, S_LEN, S_POS,
		S_TEST, S_DEC, S_RD, S_UPD, S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [31:0] maj_q, inv_maj_q, inner_q, outer_q, edge_q, slab_q, inv_bw_q;

	// Particle and tally state.
	logic [31:0] pp_q, coll_q, esc_q;
	logic [15:0] fc_q;
	logic [39:0] look_q;

	// Working registers of the current item.
	logic [31:0] u2_q, m_q, pos_q, cnt_q, sigma_q;
	logic [4:0]  zc_q, sq_q;
	logic [2:0]  step_q;
	logic [27:0] frac_q;
	logic [32:0] ln_q;
	logic [40:0] len_q;
	logic [63:0] accp_s1, binp_s1;
	logic        escp_s1;
	logic [1:0]  outcome_q;
	logic [AW-1:0] bin_q, clr_q;
	logic [6:0]  binidx_q;

	dtfs_pkg::result_t res_q;
	logic              res_valid_q;

	// Histogram RAM port.
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata, ram_rdata, ram_inc;

	// Datapath terms.
	logic [4:0]  norm_sh;
	logic [5:0]  norm_amt;
	logic [31:0] norm_hi;
	logic [63:0] sq_prod;
	logic [32:0] sq_scaled;
	logic [33:0] nl2;
	logic [63:0] ln_prod;
	logic [64:0] len_prod;
	logic [41:0] pos_sum;
	logic [11:0] bin_raw, bin_sat;
	logic [15:0] fl_next;
	logic [40:0] look_sum;
	logic [31:0] coll_next, esc_next;
	logic [39:0] look_next;
	logic        out_free;

	assign cfg_ready    = 1'b1;
	assign flight_stall = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign out_free     = !res_valid_q || !result_stall;

	// Normalisation step: test the top 16, 8, 4, 2, 1 bits in turn.
	always_comb begin
		norm_sh  = 5'd1 << step_q;
		norm_amt = 6'd32 - {1'b0, norm_sh};
		norm_hi  = m_q >> norm_amt;
	end

	// Logarithm, length and position arithmetic.
	always_comb begin
		sq_prod   = {32'd0, m_q} * {32'd0, m_q};
		sq_scaled = sq_prod[63:31];
		nl2       = {({1'b0, zc_q} + 6'd1), 28'd0} - {6'd0, frac_q};
		ln_prod   = {30'd0, nl2} * {34'd0, dtfs_pkg::LN2_Q30};
		len_prod  = {32'd0, ln_q} * {33'd0, inv_maj_q};
		pos_sum   = {10'd0, pp_q} + {1'b0, len_q};
		bin_raw   = binp_s1[63:52];
		bin_sat   = (bin_raw > TOP_BIN) ? TOP_BIN : bin_raw;
	end

	// Tally updates applied when the result is loaded.
	always_comb begin
		fl_next   = (fc_q == dtfs_pkg::MAX16) ? fc_q : fc_q + 16'd1;
		coll_next = coll_q;
		esc_next  = esc_q;
		look_next = look_q;
		look_sum  = {1'b0, look_q} + {25'd0, fl_next};
		if (outcome_q == dtfs_pkg::OUT_REAL && coll_q != dtfs_pkg::MAX32) begin
			coll_next = coll_q + 32'd1;
		end
		if (outcome_q == dtfs_pkg::OUT_ESCAPE && esc_q != dtfs_pkg::MAX32) begin
			esc_next = esc_q + 32'd1;
		end
		if (outcome_q == dtfs_pkg::OUT_REAL || outcome_q == dtfs_pkg::OUT_ESCAPE) begin
			look_next = look_sum[40] ? dtfs_pkg::MAX40 : look_sum[39:0];
		end
	end

	// Histogram RAM access: clearing pass, read of a bin, or increment of the struck bin.
	always_comb begin
		ram_inc   = (ram_rdata == dtfs_pkg::MAX32) ? ram_rdata : ram_rdata + 32'd1;
		ram_addr  = (state_q == S_CLR) ? clr_q : bin_q;
		ram_we    = (state_q == S_CLR) ||
			(state_q == S_UPD && outcome_q == dtfs_pkg::OUT_REAL);
		ram_wdata = (state_q == S_CLR) ? 32'd0 : ram_inc;
	end

	dtfs_ram #(
		.WIDTH(32),
		.DEPTH(BINS)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maj_q     <= dtfs_pkg::RST_MAJORANT;
			inv_maj_q <= dtfs_pkg::RST_INV_MAJORANT;
			inner_q   <= dtfs_pkg::RST_INNER_XS;
			outer_q   <= dtfs_pkg::RST_OUTER_XS;
			edge_q    <= dtfs_pkg::RST_STEP_EDGE;
			slab_q    <= dtfs_pkg::RST_SLAB_THICK;
			inv_bw_q  <= dtfs_pkg::RST_INV_BIN_WIDTH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dtfs_pkg::REG_MAJORANT:      maj_q     <= cfg_data;
				dtfs_pkg::REG_INV_MAJORANT:  inv_maj_q <= cfg_data;
				dtfs_pkg::REG_INNER_XS:      inner_q   <= cfg_data;
				dtfs_pkg::REG_OUTER_XS:      outer_q   <= cfg_data;
				dtfs_pkg::REG_STEP_EDGE:     edge_q    <= cfg_data;
				dtfs_pkg::REG_SLAB_THICK:    slab_q    <= cfg_data;
				dtfs_pkg::REG_INV_BIN_WIDTH: inv_bw_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer with its datapath and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
			pp_q        <= '0;
			fc_q        <= '0;
			coll_q      <= '0;
			esc_q       <= '0;
			look_q      <= '0;
		end else begin
			// The result is offered from its load until it is taken.
			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (12'(clr_q) == TOP_BIN) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (flight_valid) begin
						u2_q     <= flight.accept_uniform;
						m_q      <= flight.distance_uniform;
						zc_q     <= '0;
						step_q   <= 3'd4;
						sq_q     <= '0;
						frac_q   <= '0;
						binidx_q <= '0;
						cnt_q    <= '0;
						if (flight.func == dtfs_pkg::FUNC_READ) begin
							outcome_q <= dtfs_pkg::OUT_READ;
							binidx_q  <= flight.read_bin;
							bin_q     <= AW'(flight.read_bin);
							if ({25'd0, flight.read_bin} < 32'(BINS)) begin
								state_q <= S_RD;
							end else begin
								state_q <= S_OUT;
							end
						end else if (flight.distance_uniform == 32'd0) begin
							pos_q   <= dtfs_pkg::MAX32;
							state_q <= S_TEST;
						end else begin
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					if (norm_hi == 32'd0) begin
						m_q  <= m_q << norm_sh;
						zc_q <= zc_q + norm_sh;
					end
					step_q <= step_q - 3'd1;
					if (step_q == 3'd0) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					// One fraction bit of log2 per squaring.
					if (sq_scaled[32]) begin
						m_q <= sq_scaled[32:1];
					end else begin
						m_q <= sq_scaled[31:0];
					end
					frac_q <= {frac_q[26:0], sq_scaled[32]};
					sq_q   <= sq_q + 5'd1;
					if (sq_q == 5'(dtfs_pkg::LOG_FRAC_BITS - 1)) begin
						state_q <= S_LN;
					end
				end
				S_LN: begin
					ln_q    <= ln_prod[62:30];
					state_q <= S_LEN;
				end
				S_LEN: begin
					len_q   <= len_prod[64:24];
					state_q <= S_POS;
				end
				S_POS: begin
					pos_q   <= (pos_sum > {10'd0, dtfs_pkg::MAX32}) ?
						dtfs_pkg::MAX32 : pos_sum[31:0];
					state_q <= S_TEST;
				end
				S_TEST: begin
					accp_s1 <= {32'd0, u2_q} * {32'd0, maj_q};
					binp_s1 <= {32'd0, pos_q} * {32'd0, inv_bw_q};
					escp_s1 <= (pos_q >= slab_q);
					sigma_q <= (pos_q < edge_q) ? inner_q : outer_q;
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (escp_s1) begin
						outcome_q <= dtfs_pkg::OUT_ESCAPE;
						state_q   <= S_OUT;
					end else if (accp_s1 < {sigma_q, 32'd0}) begin
						outcome_q <= dtfs_pkg::OUT_REAL;
						bin_q     <= AW'(bin_sat);
						binidx_q  <= bin_sat[6:0];
						state_q   <= S_RD;
					end else begin
						outcome_q <= dtfs_pkg::OUT_VIRTUAL;
						state_q   <= S_OUT;
					end
				end
				S_RD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					cnt_q   <= (outcome_q == dtfs_pkg::OUT_REAL) ? ram_inc : ram_rdata;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						res_q.outcome       <= outcome_q;
						res_q.bin_index     <= binidx_q;
						res_q.bin_count     <= cnt_q;
						res_q.collision_total <= coll_next;
						res_q.escape_total  <= esc_next;
						res_q.lookup_total  <= look_next;
						coll_q              <= coll_next;
						esc_q               <= esc_next;
						look_q              <= look_next;
						if (outcome_q == dtfs_pkg::OUT_READ) begin
							res_q.position           <= pp_q;
							res_q.flights_in_history <= fc_q;
						end else begin
							res_q.position           <= pos_q;
							res_q.flights_in_history <= fl_next;
							if (outcome_q == dtfs_pkg::OUT_VIRTUAL) begin
								pp_q <= pos_q;
								fc_q <= fl_next;
							end else begin
								pp_q <= '0;
								fc_q <= '0;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/dtfs_checker.sv
// Port checker for the delta-tracking flight step block, bound to its top level.
// Depends on dtfs_pkg and delta_tracking_flight_step.
module dtfs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             result_valid,
	input logic                             result_stall,
	input dtfs_pkg::result_t                result
);

	// A stalled result item stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result item withdrawn while stalled");

	// A stalled result item keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	// A real collision always reports a nonzero bin count and collision total.
	a_real_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.outcome == dtfs_pkg::OUT_REAL |->
		result.bin_count != 32'd0 && result.collision_total != 32'd0)
		else $error("real collision with zero count");

	// Virtual collisions and escapes touch no bin.
	a_no_bin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.outcome == dtfs_pkg::OUT_VIRTUAL ||
		result.outcome == dtfs_pkg::OUT_ESCAPE) |->
		result.bin_index == 7'd0 && result.bin_count == 32'd0)
		else $error("bin reported without a real collision");

	// Collision and escape totals never fall between successive result items.
	a_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid) |->
		result.collision_total >= $past(result.collision_total) &&
		result.escape_total >= $past(result.escape_total))
		else $error("tally decreased");

endmodule

bind delta_tracking_flight_step dtfs_checker u_dtfs_checker (.*);
